>>> design/ssl_pkg.sv
// ----------------------------------------------------------------------------
// ssl_pkg: schedule speed limiter shared definitions
// Constants, outcome codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none
package ssl_pkg;

   localparam logic [31:0] LEG_SPEED_RESET = 32'd65536;
   localparam logic [31:0] TIME_TOL_Q      = 32'd131072;
   localparam logic [31:0] MIN_SPEED_Q     = 32'd6554;
   localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
   localparam logic [34:0] SLOW_LIMIT      = 35'd65536;

   // outcome codes
   localparam logic [1:0] OUT_NEW_LEG  = 2'd0;
   localparam logic [1:0] OUT_HELD     = 2'd1;
   localparam logic [1:0] OUT_ON_SCHED = 2'd2;
   localparam logic [1:0] OUT_SCALED   = 2'd3;

   // one-hot sequencer states
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SQX   = 8'b0000_0010,
      ST_SQY   = 8'b0000_0100,
      ST_ROOT  = 8'b0000_1000,
      ST_DIV1  = 8'b0001_0000,
      ST_MUL   = 8'b0010_0000,
      ST_DIV2  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

endpackage
`default_nettype wire

>>> design/ssl_if.sv
// ----------------------------------------------------------------------------
// ssl_req_if / ssl_rsp_if: valid/ready channels of the speed limiter
// Each carries one item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface ssl_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] goal_x;
   logic [31:0] goal_y;
   logic [31:0] tolerance_radius;
   logic [31:0] time_left;
   logic [31:0] speed_cap_in;
   logic [31:0] turn_cap_in;
   logic [31:0] current_speed;
   modport source (output valid, mode, goal_x, goal_y, tolerance_radius, time_left,
                   speed_cap_in, turn_cap_in, current_speed, input ready);
   modport sink (input valid, mode, goal_x, goal_y, tolerance_radius, time_left,
                 speed_cap_in, turn_cap_in, current_speed, output ready);
endinterface

interface ssl_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] speed_cap_out;
   logic [31:0] turn_cap_out;
   logic [1:0]  outcome;
   modport source (output valid, speed_cap_out, turn_cap_out, outcome, input ready);
   modport sink (input valid, speed_cap_out, turn_cap_out, outcome, output ready);
endinterface
`default_nettype wire

>>> design/ssl_serial_unit.sv
// ----------------------------------------------------------------------------
// ssl_serial_unit: bit-serial multiply, root and divide
// One bit per cycle for each operation; narrow add/sub datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module ssl_serial_unit
   import ssl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start_mul,   // a*b, 32x32 -> 64
   input  wire logic        start_root,  // floor sqrt of 64-bit op_wide
   input  wire logic        start_div,   // 64-bit op_wide / op_b, 64-bit quotient
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   input  wire logic [63:0] op_wide,
   output logic             busy,
   output logic [63:0]      result
);
   typedef enum logic [3:0] {
      U_IDLE = 4'b0001, U_MUL = 4'b0010, U_ROOT = 4'b0100, U_DIV = 4'b1000
   } ustate_type;

   ustate_type  st_ff, st_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;     // product / quotient / root
   logic [63:0] sh_ff, sh_in;       // multiplier / dividend / radicand shifter
   logic [65:0] rem_ff, rem_in;     // remainder
   logic [31:0] b_ff, b_in;

   logic [65:0] trial;
   logic [65:0] rtrial;

   assign busy   = (st_ff != U_IDLE);
   assign result = acc_ff;

   always_comb begin
      st_in  = st_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      sh_in  = sh_ff;
      rem_in = rem_ff;
      b_in   = b_ff;
      trial  = {rem_ff[64:0], sh_ff[63]} - {34'd0, b_ff};
      rtrial = {rem_ff[63:0], sh_ff[63:62]} - {acc_ff[63:0], 2'b01};
      case (st_ff)
         U_IDLE: begin
            if (start_mul) begin
               st_in = U_MUL; cnt_in = 7'd32; acc_in = '0;
               sh_in = {32'd0, op_a}; b_in = op_b;
            end else if (start_root) begin
               st_in = U_ROOT; cnt_in = 7'd32; acc_in = '0;
               sh_in = op_wide; rem_in = '0;
            end else if (start_div) begin
               st_in = U_DIV; cnt_in = 7'd64; acc_in = '0;
               sh_in = op_wide; rem_in = '0; b_in = op_b;
            end
         end
         // shift-add, multiplier bits from LSB
         U_MUL: begin
            acc_in = {1'b0, acc_ff[63:1]};
            if (sh_ff[0]) acc_in = {1'b0, acc_ff[63:1]} + {1'b0, b_ff, 31'd0};
            sh_in  = {1'b0, sh_ff[63:1]};
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) st_in = U_IDLE;
         end
         // restoring root, two radicand bits per step
         U_ROOT: begin
            sh_in = {sh_ff[61:0], 2'b00};
            if (!rtrial[65]) begin
               rem_in = rtrial;
               acc_in = {acc_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[63:0], sh_ff[63:62]};
               acc_in = {acc_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) st_in = U_IDLE;
         end
         // restoring division, one quotient bit per step
         U_DIV: begin
            sh_in = {sh_ff[62:0], 1'b0};
            if (!trial[65]) begin
               rem_in = trial;
               acc_in = {acc_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[64:0], sh_ff[63]};
               acc_in = {acc_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) st_in = U_IDLE;
         end
         default: st_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= U_IDLE;
         cnt_ff <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      b_ff   <= b_in;
   end

   a_cnt_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != U_IDLE) |-> (cnt_ff != 7'd0))
      else $error("serial unit busy with zero count");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != U_IDLE) |=> ($past(cnt_ff) == cnt_ff + 7'd1))
      else $error("serial count did not step");
   a_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0({start_mul && !busy, start_root && !busy, start_div && !busy})
      || (start_mul && !busy))
      else $error("serial unit start conflict");
endmodule
`default_nettype wire

>>> design/schedule_speed_limiter_top.sv
// ----------------------------------------------------------------------------
// schedule_speed_limiter_top: paces a robot leg against its schedule
// Q16.16 speed limiter with a shared bit-serial arithmetic unit.
// ----------------------------------------------------------------------------
// One item is worked at a time. A leg start (mode 0) squares both goal
// offsets, takes the root and divides the border by the time left, with the
// divide skipped when no time is left; a constrain item squares, takes the
// root, divides, multiplies and divides again, skips the first divide when
// the leg speed is zero and everything after the root when it is held at the
// goal. All of it runs on the single bit-serial unit: each squaring, the root
// and the multiply take 32 steps, each divide 64. The result register frees
// the input side as soon as the result is loaded; a result that is still not
// taken holds the block in its last state until it is.
`default_nettype none
module schedule_speed_limiter_top
   import ssl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ssl_req_if.sink   req,
   ssl_rsp_if.source rsp
);
   state_type   st_ff, st_in;
   logic        mode_ff;
   logic [31:0] mx_ff, my_ff, tol_ff, tleft_ff, scap_ff, tcap_ff, cur_ff;
   logic [63:0] sum_ff;
   logic [31:0] border_ff;
   logic [31:0] tint_ff;
   logic        held_ff;
   logic [31:0] leg_ff;
   logic        rv_ff;
   logic [31:0] ro_spd_ff, ro_turn_ff;
   logic [1:0]  ro_oc_ff;
   logic        go_ff;  // unit started this state

   logic        u_mul, u_root, u_div, u_busy;
   logic [31:0] u_a, u_b;
   logic [63:0] u_wide, u_res;
   logic [31:0] sat_res, diff, req_v;
   logic [31:0] goal_dist;
   logic        held_now;

   ssl_serial_unit u_ser (
      .clock(clock), .reset(reset), .start_mul(u_mul), .start_root(u_root),
      .start_div(u_div), .op_a(u_a), .op_b(u_b), .op_wide(u_wide),
      .busy(u_busy), .result(u_res));

   function automatic logic [31:0] mag(input logic [31:0] v);
      mag = v[31] ? (32'd0 - v) : v;
   endfunction

   assign req.ready = (st_ff == ST_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.speed_cap_out = ro_spd_ff;
   assign rsp.turn_cap_out  = ro_turn_ff;
   assign rsp.outcome       = ro_oc_ff;

   assign sat_res   = (u_res[63:32] != 32'd0) ? ALL_ONES : u_res[31:0];
   assign goal_dist = u_res[31:0];
   assign diff    = (tint_ff >= tleft_ff) ? tint_ff - tleft_ff : tleft_ff - tint_ff;
   // at goal, waiting and slow, valid when the root completes
   assign held_now = (goal_dist <= tol_ff) && (tleft_ff != 32'd0)
                     && (({3'd0, cur_ff} + {1'b0, cur_ff, 2'b00}) < SLOW_LIMIT);
   // unit start strobes, once per state
   assign u_mul  = !go_ff && ((st_ff == ST_SQX) || (st_ff == ST_SQY) || (st_ff == ST_MUL));
   assign u_root = !go_ff && (st_ff == ST_ROOT);
   assign u_div  = !go_ff && ((st_ff == ST_DIV1) || (st_ff == ST_DIV2));

   always_comb begin
      u_a = mx_ff; u_b = mx_ff; u_wide = sum_ff;
      case (st_ff)
         ST_SQY:  begin u_a = my_ff; u_b = my_ff; end
         ST_MUL:  begin u_a = leg_ff; u_b = tint_ff; end
         ST_DIV1: begin
            u_wide = {16'd0, border_ff, 16'd0};
            u_b    = mode_ff ? leg_ff : tleft_ff;
         end
         ST_DIV2: begin u_wide = sum_ff; u_b = tleft_ff; end
         default: ;
      endcase
   end

   assign req_v = (sat_res < MIN_SPEED_Q) ? ((MIN_SPEED_Q > scap_ff) ? scap_ff : MIN_SPEED_Q)
                : ((sat_res > scap_ff) ? scap_ff : sat_res);

   // sequencer
   always_comb begin
      st_in  = st_ff;
      case (st_ff)
         ST_IDLE: if (req.valid) st_in = ST_SQX;
         ST_SQX:  if (go_ff && !u_busy) st_in = ST_SQY;
         ST_SQY:  if (go_ff && !u_busy) st_in = ST_ROOT;
         ST_ROOT: if (go_ff && !u_busy) begin
            if (mode_ff && held_now) st_in = ST_DONE;
            else if (!mode_ff && tleft_ff == 32'd0) st_in = ST_DONE;
            else if (mode_ff && leg_ff == 32'd0) st_in = ST_MUL;
            else st_in = ST_DIV1;
         end
         ST_DIV1: if (go_ff && !u_busy) st_in = mode_ff ? ST_MUL : ST_DONE;
         ST_MUL:  if (go_ff && !u_busy) st_in = ST_DIV2;
         ST_DIV2: if (go_ff && !u_busy) st_in = ST_DONE;
         ST_DONE: if (!rv_ff || rsp.ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         go_ff  <= 1'b0;
         rv_ff  <= 1'b0;
         leg_ff <= LEG_SPEED_RESET;
      end else begin
         st_ff <= st_in;
         go_ff <= (st_in == st_ff) && (st_ff != ST_IDLE) && (st_ff != ST_DONE);
         // result load
         if (st_ff == ST_DONE && (!rv_ff || rsp.ready)) begin
            rv_ff <= 1'b1;
            if (!mode_ff) begin
               ro_oc_ff <= OUT_NEW_LEG;
               ro_turn_ff <= tcap_ff;
               ro_spd_ff <= leg_ff;
            end else if (held_ff) begin
               ro_oc_ff <= OUT_HELD; ro_spd_ff <= '0; ro_turn_ff <= '0;
            end else if (diff < TIME_TOL_Q) begin
               ro_oc_ff <= OUT_ON_SCHED; ro_spd_ff <= leg_ff; ro_turn_ff <= tcap_ff;
            end else begin
               ro_oc_ff <= OUT_SCALED; ro_turn_ff <= tcap_ff;
               if (tleft_ff == 32'd0)
                  ro_spd_ff <= (leg_ff == 32'd0)
                     ? ((MIN_SPEED_Q > scap_ff) ? scap_ff : MIN_SPEED_Q)
                     : scap_ff;
               else ro_spd_ff <= req_v;
            end
         end else if (rv_ff && rsp.ready) begin
            rv_ff <= 1'b0;
         end
         // leg speed on mode 0
         if (!mode_ff && st_ff == ST_ROOT && go_ff && !u_busy && tleft_ff == 32'd0)
            leg_ff <= ALL_ONES;
         if (!mode_ff && st_ff == ST_DIV1 && go_ff && !u_busy)
            leg_ff <= sat_res;
      end
      if (st_ff == ST_IDLE && req.valid) begin
         mode_ff  <= req.mode;
         mx_ff    <= mag(req.goal_x);
         my_ff    <= mag(req.goal_y);
         tol_ff   <= req.tolerance_radius;
         tleft_ff <= req.time_left;
         scap_ff  <= req.speed_cap_in;
         tcap_ff  <= req.turn_cap_in;
         cur_ff   <= req.current_speed;
      end
      if (st_ff == ST_SQX && go_ff && !u_busy) sum_ff <= u_res;
      if (st_ff == ST_SQY && go_ff && !u_busy) sum_ff <= sum_ff + u_res;
      if (st_ff == ST_ROOT && go_ff && !u_busy) begin
         border_ff <= (goal_dist > tol_ff) ? goal_dist - tol_ff : 32'd0;
         held_ff   <= held_now;
         if (leg_ff == 32'd0) tint_ff <= ALL_ONES;
      end
      if (st_ff == ST_DIV1 && go_ff && !u_busy) tint_ff <= sat_res;
      if (st_ff == ST_MUL && go_ff && !u_busy) sum_ff <= u_res;
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (st_ff == ST_SQX))
      else $error("accepted item did not start");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp.ready) |=> rv_ff)
      else $error("result dropped while stalled");
   a_held_turn: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && ro_oc_ff == OUT_HELD) |-> (ro_turn_ff == 32'd0 && ro_spd_ff == 32'd0))
      else $error("held result not zero");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !req.ready)
      else $error("ready while busy");
endmodule
`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: schedule speed limiter check
// Drives leg starts and constrain items with random bursts and stalls and
// compares every result against a cycle-free model of the pacing rules.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench
   import ssl_pkg::*;
();

   typedef struct {
      logic        mode;
      logic [31:0] goal_x;
      logic [31:0] goal_y;
      logic [31:0] tol;
      logic [31:0] tleft;
      logic [31:0] scap;
      logic [31:0] tcap;
      logic [31:0] cur;
   } cmd_type;

   typedef struct {
      logic [31:0] speed;
      logic [31:0] turn;
      logic [1:0]  outcome;
   } limit_type;

   // pacing model plus queue of expected limits
   class pace_board;
      logic [31:0] leg_speed;
      limit_type   pending[$];
      int          errors;

      function new();
         leg_speed = LEG_SPEED_RESET;
         errors = 0;
      endfunction

      function logic [63:0] mag(logic [31:0] v);
         return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
      endfunction

      function logic [31:0] isqrt(logic [63:0] v);
         logic [63:0] r;
         r = 0;
         for (int i = 31; i >= 0; i--) begin
            logic [63:0] t;
            t = r | (64'd1 << i);
            if (t * t <= v) r = t;
         end
         return r[31:0];
      endfunction

      function logic [31:0] sat(logic [63:0] v);
         return (v > 64'hFFFF_FFFF) ? ALL_ONES : v[31:0];
      endfunction

      function logic [31:0] qdiv(logic [31:0] a, logic [31:0] b);
         return sat({a, 16'd0} / {32'd0, b});
      endfunction

      function void note_cmd(cmd_type c);
         logic [63:0] mx, my;
         logic [31:0] goal_dist, border, t_int, diff, req;
         limit_type e;
         mx = mag(c.goal_x);
         my = mag(c.goal_y);
         goal_dist = isqrt(mx * mx + my * my);
         border = (goal_dist > c.tol) ? goal_dist - c.tol : 32'd0;
         e.turn = c.tcap;
         if (!c.mode) begin
            leg_speed = (c.tleft == 0) ? ALL_ONES : qdiv(border, c.tleft);
            e.speed = leg_speed;
            e.outcome = OUT_NEW_LEG;
         end else if (goal_dist <= c.tol && c.tleft != 0
                      && {32'd0, c.cur} * 5 < 64'd65536) begin
            e.speed = 0;
            e.turn = 0;
            e.outcome = OUT_HELD;
         end else begin
            t_int = (leg_speed == 0) ? ALL_ONES : qdiv(border, leg_speed);
            diff = (t_int >= c.tleft) ? t_int - c.tleft : c.tleft - t_int;
            if (diff < TIME_TOL_Q) begin
               e.speed = leg_speed;
               e.outcome = OUT_ON_SCHED;
            end else begin
               if (c.tleft == 0) req = (leg_speed == 0) ? 32'd0 : ALL_ONES;
               else req = sat(({32'd0, leg_speed} * {32'd0, t_int}) / {32'd0, c.tleft});
               if (req < MIN_SPEED_Q) req = MIN_SPEED_Q;
               if (req > c.scap) req = c.scap;
               e.speed = req;
               e.outcome = OUT_SCALED;
            end
         end
         pending.push_back(e);
      endfunction

      function void check_limit(limit_type a);
         limit_type e;
         if (pending.size() == 0) begin
            $error("unexpected result speed=%h", a.speed);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.speed !== e.speed) begin
            $error("speed_cap_out exp %h got %h", e.speed, a.speed); errors++;
         end
         if (a.turn !== e.turn) begin
            $error("turn_cap_out exp %h got %h", e.turn, a.turn); errors++;
         end
         if (a.outcome !== e.outcome) begin
            $error("outcome exp %0d got %0d", e.outcome, a.outcome); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   ssl_req_if req ();
   ssl_rsp_if rsp ();
   pace_board board = new();
   int  stall_hold = 0;

   schedule_speed_limiter_top u_dut (.clock(clock), .reset(reset), .req(req.sink),
                                     .rsp(rsp.source));

   always #5 clock = ~clock;

   initial begin
      req.valid = 0; req.mode = 0; req.goal_x = 0; req.goal_y = 0;
      req.tolerance_radius = 0; req.time_left = 0; req.speed_cap_in = 0;
      req.turn_cap_in = 0; req.current_speed = 0; rsp.ready = 0;
   end

   // result side: stall pattern plus long hold-offs
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready)
            board.check_limit('{rsp.speed_cap_out, rsp.turn_cap_out, rsp.outcome});
         if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            rsp.ready <= 0;
         end else begin
            rsp.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return ALL_ONES;
         2: return 32'h8000_0000;
         3: return $urandom_range(0, 32'h0004_0000);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_cmd(cmd_type c);
      req.valid <= 1;
      req.mode <= c.mode;
      req.goal_x <= c.goal_x;
      req.goal_y <= c.goal_y;
      req.tolerance_radius <= c.tol;
      req.time_left <= c.tleft;
      req.speed_cap_in <= c.scap;
      req.turn_cap_in <= c.tcap;
      req.current_speed <= c.cur;
      do @(posedge clock); while (!req.ready);
      board.note_cmd(c);
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req.valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // one command of the given mode: bounded random fields when plausible, else corner words
   function automatic cmd_type make_cmd(bit mode, bit plausible);
      cmd_type c;
      c.mode = mode;
      if (plausible) begin
         c.goal_x = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
         c.goal_y = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
         c.tol = $urandom_range(0, 32'h0004_0000);
         c.tleft = $urandom_range(0, 32'h0080_0000);
         c.scap = $urandom_range(0, 32'h0004_0000);
         c.cur = $urandom_range(0, 32'h0000_8000);
      end else begin
         c.goal_x = rand_word(); c.goal_y = rand_word(); c.tol = rand_word();
         c.tleft = rand_word(); c.scap = rand_word(); c.cur = rand_word();
      end
      c.tcap = $urandom;
      return c;
   endfunction

   initial begin
      cmd_type c;
      int   n;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners
      send_cmd('{1, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h1234, 0});      // held
      send_cmd('{1, 0, 0, 0, 0, 5, ALL_ONES, 0});                              // no time, at goal
      send_cmd('{1, 0, 0, 0, 32'h0001_0000, 7, 3, 32'h0000_3334});            // at goal, fast
      send_cmd('{0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, ALL_ONES, 0});      // no time left
      send_cmd('{1, 32'h8000_0000, 32'h8000_0000, 0, 0, ALL_ONES, 1, 0});      // no time, on schedule
      send_cmd('{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 0, 0, 0});             // huge quotient
      send_cmd('{0, 0, 0, ALL_ONES, 32'h0010_0000, 0, 5, 0});                  // zero leg speed
      send_cmd('{1, 32'h0010_0000, 0, 0, 32'h0010_0000, ALL_ONES, 9, ALL_ONES});
      send_cmd('{1, 32'h0010_0000, 0, 0, 0, ALL_ONES, 9, ALL_ONES});           // zero speed, no time
      send_cmd('{0, 32'h000A_0000, 32'hFFF6_0000, 0, 32'h000A_0000, 0, 2, 0});
      send_cmd('{1, 32'h000A_0000, 32'hFFF6_0000, 0, 32'h000A_0000, ALL_ONES, 2, 0}); // on sched
      send_cmd('{1, 32'h000A_0000, 0, 0, 32'h0064_0000, ALL_ONES, 2, 0});      // floor
      send_cmd('{1, 32'h0064_0000, 0, 0, 32'h0002_0000, 32'h0000_8000, 2, 0}); // cap
      send_cmd('{1, ALL_ONES, ALL_ONES, 32'h7FFF_FFFF, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES});
      drain();

      // random legs in bursts
      n = 0;
      while (n < 800) begin
         int burst;
         burst = $urandom_range(1, 12);
         if (n > 300 && n < 320) stall_hold = 3000;   // fill up and back-pressure
         repeat (burst) begin
            bit ok;
            ok = ($urandom_range(0, 4) != 0);
            c = make_cmd(($urandom_range(0, 3) != 0), ok);
            send_cmd(c);
            n++;
         end
         if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 400));
         if ($urandom_range(0, 30) == 0) drain();
      end
      drain();
      repeat (500) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("schedule_speed_limiter_top: match");
      else
         $display("schedule_speed_limiter_top: mismatch");
      $finish;
   end

   initial begin
      #30000000;
      $display("schedule_speed_limiter_top: mismatch");
      $finish;
   end
endmodule
`default_nettype wire
